### hdl/rrd_pkg.sv
// Shared types and constants of the RGBE run-length scanline decoder.
// No dependencies; imported by the sequencer, the pixel packer and the top level.
package rrd_pkg;

  localparam int BYTE_W     = 8;
  localparam int COLUMN_W   = 12;
  localparam int ROW_W      = 15;
  localparam int WIDTH_W    = 13;
  localparam int SPAN_W     = 9;
  localparam int HDR_W      = 3;
  localparam int RGB_W      = 24;
  localparam int PIXEL_W    = 32;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  // Coding constants of the scanline format.
  localparam logic [BYTE_W-1:0] RUN_BIAS     = 8'd128;
  localparam logic [SPAN_W-1:0] LIT_FULL     = 9'd256;
  localparam logic [HDR_W-1:0]  HEADER_BYTES = 3'd4;
  localparam logic [1:0]        PLANE_E      = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // One finished exponent byte handed from the sequencer to the packer.
  typedef struct packed {
    logic                vld;
    logic [BYTE_W-1:0]   e_byte;
    logic [COLUMN_W-1:0] col;
    logic [ROW_W-1:0]    row;
    logic                last;
    logic                ended;
    logic                done;
  } pix_evt_t;

endpackage

### hdl/rrd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the R, G and B planes of the row store.
module rrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/rrd_seq.sv
// Byte sequencer: header skip, count/value parsing and the column write loop.
// Depends on rrd_pkg; drives the row store RAMs and feeds rrd_pack.
module rrd_seq #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [rrd_pkg::WIDTH_W-1:0]      image_width,
  input  logic [rrd_pkg::ROW_W-1:0]        image_height,
  input  logic                             byte_vld,
  output logic                             byte_rdy,
  input  logic [rrd_pkg::BYTE_W-1:0]       byte_in,
  output logic [2:0]                       row_we,
  output logic                             row_re,
  output logic [$clog2(MAX_WIDTH)-1:0]     row_addr,
  output logic [rrd_pkg::BYTE_W-1:0]       row_wdata,
  output rrd_pkg::pix_evt_t                evt,
  input  logic                             evt_take
);
  import rrd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_PIX  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [1:0]          plane_r, plane_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [HDR_W-1:0]    hdr_r, hdr_nxt;
  logic [SPAN_W-1:0]   span_r, span_nxt;
  logic                await_r, await_nxt;
  logic                done_r, done_nxt;
  logic [BYTE_W-1:0]   val_r, val_nxt;
  logic                lit_r, lit_nxt;
  logic [ROW_W-1:0]    brow_r, brow_nxt;
  logic [COLUMN_W-1:0] pcol_r, pcol_nxt;
  logic                plast_r, plast_nxt;
  logic                pended_r, pended_nxt;
  logic                pdone_r, pdone_nxt;

  logic [15:0]       w_ext, w_eff, h_ext, h_eff, col_inc, row_inc;
  logic              ended, last_row, burst_done;
  logic [SPAN_W-1:0] span_dec;

  // Effective width and height, clamped to the legal range.
  always_comb begin
    w_ext = {3'b000, image_width};
    if (w_ext == 16'd0) begin
      w_eff = 16'd1;
    end else if (w_ext > 16'(MAX_WIDTH)) begin
      w_eff = 16'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_ext = {1'b0, image_height};
    h_eff = (h_ext == 16'd0) ? 16'd1 : h_ext;
  end

  // Shared column and row step: one increment and compare each.
  assign col_inc    = 16'(col_r) + 16'd1;
  assign row_inc    = 16'(row_r) + 16'd1;
  assign ended      = (col_inc >= w_eff);
  assign last_row   = (row_inc >= h_eff);
  assign span_dec   = span_r - 9'd1;
  assign burst_done = ended || lit_r || (span_dec == '0);

  // Sequencer next state.
  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    plane_nxt  = plane_r;
    row_nxt    = row_r;
    hdr_nxt    = hdr_r;
    span_nxt   = span_r;
    await_nxt  = await_r;
    done_nxt   = done_r;
    val_nxt    = val_r;
    lit_nxt    = lit_r;
    brow_nxt   = brow_r;
    pcol_nxt   = pcol_r;
    plast_nxt  = plast_r;
    pended_nxt = pended_r;
    pdone_nxt  = pdone_r;
    row_we     = 3'b000;
    row_re     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (byte_vld) begin
          priority if (done_r) begin
            // Image complete: bytes are dropped.
          end else if (hdr_r != '0) begin
            hdr_nxt = hdr_r - 3'd1;
          end else if (!await_r && span_r == '0) begin
            if (byte_in > RUN_BIAS) begin
              await_nxt = 1'b1;
              span_nxt  = {1'b0, byte_in} - {1'b0, RUN_BIAS};
            end else begin
              span_nxt  = (byte_in == '0) ? LIT_FULL : {1'b0, byte_in};
            end
          end else if (await_r) begin
            await_nxt = 1'b0;
            val_nxt   = byte_in;
            lit_nxt   = 1'b0;
            brow_nxt  = row_r;
            state_nxt = S_STEP;
          end else begin
            val_nxt   = byte_in;
            lit_nxt   = 1'b1;
            brow_nxt  = row_r;
            state_nxt = S_STEP;
          end
        end
      end

      S_STEP: begin
        span_nxt   = span_dec;
        pcol_nxt   = COLUMN_W'(col_r);
        plast_nxt  = burst_done;
        pended_nxt = ended;
        pdone_nxt  = ended && (plane_r == PLANE_E) && last_row;
        if (plane_r == PLANE_E) begin
          row_re = 1'b1;
        end else begin
          row_we[plane_r] = 1'b1;
        end
        if (ended) begin
          col_nxt   = '0;
          span_nxt  = '0;
          await_nxt = 1'b0;
          if (plane_r == PLANE_E) begin
            plane_nxt = 2'd0;
            hdr_nxt   = HEADER_BYTES;
            if (last_row) begin
              done_nxt = 1'b1;
            end else begin
              row_nxt = ROW_W'(row_inc);
            end
          end else begin
            plane_nxt = plane_r + 2'd1;
          end
        end else begin
          col_nxt = COL_W'(col_inc);
        end
        if (plane_r == PLANE_E) begin
          state_nxt = S_PIX;
        end else if (burst_done) begin
          state_nxt = S_IDLE;
        end
      end

      S_PIX: begin
        if (evt_take) begin
          state_nxt = plast_r ? S_IDLE : S_STEP;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      plane_r <= 2'd0;
      row_r   <= '0;
      hdr_r   <= HEADER_BYTES;
      span_r  <= '0;
      await_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      plane_r <= plane_nxt;
      row_r   <= row_nxt;
      hdr_r   <= hdr_nxt;
      span_r  <= span_nxt;
      await_r <= await_nxt;
      done_r  <= done_nxt;
    end
  end

  // Burst payload registers.
  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    lit_r    <= lit_nxt;
    brow_r   <= brow_nxt;
    pcol_r   <= pcol_nxt;
    plast_r  <= plast_nxt;
    pended_r <= pended_nxt;
    pdone_r  <= pdone_nxt;
  end

  assign byte_rdy  = (state_r == S_IDLE);
  assign row_addr  = col_r;
  assign row_wdata = val_r;

  always_comb begin
    evt.vld    = (state_r == S_PIX);
    evt.e_byte = val_r;
    evt.col    = pcol_r;
    evt.row    = brow_r;
    evt.last   = plast_r;
    evt.ended  = pended_r;
    evt.done   = pdone_r;
  end

  // The column counter never leaves the row store.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < MAX_WIDTH)
    else $error("column counter beyond row store depth");

  // A pending run value always has a nonzero run length below the bias.
  a_await_span: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (span_r != '0) && (span_r < {1'b0, RUN_BIAS}))
    else $error("run awaits value with bad length");

  // A plane end always closes the burst that caused it.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) && ended |=> plast_r)
    else $error("plane end not marked as last of burst");

endmodule

### hdl/rrd_pack.sv
// Pixel packer: pairs neighboring pixels and holds the output register.
// Depends on rrd_pkg; fed by rrd_seq and the row store read data.
module rrd_pack (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rrd_pkg::pix_evt_t                evt,
  input  logic [rrd_pkg::RGB_W-1:0]        rgb,
  output logic                             evt_take,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rrd_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);
  import rrd_pkg::*;

  logic                  have_left_r, have_left_nxt;
  logic [PIXEL_W-1:0]    left_r, left_nxt;
  logic [COLUMN_W-1:0]   left_col_r, left_col_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [PIXEL_W-1:0]    o_left_r, o_left_nxt;
  logic [PIXEL_W-1:0]    o_right_r, o_right_nxt;
  logic                  o_rv_r, o_rv_nxt;
  logic [COLUMN_W-1:0]   o_col_r, o_col_nxt;
  logic [ROW_W-1:0]      o_row_r, o_row_nxt;
  logic                  o_last_r, o_last_nxt;
  logic                  o_rend_r, o_rend_nxt;
  logic                  o_iend_r, o_iend_nxt;
  logic [PIXEL_W-1:0]    pixel;
  logic                  slot_free;

  assign pixel     = {rgb, evt.e_byte};
  assign slot_free = !out_vld_r || out_tready;
  assign evt_take  = evt.vld && slot_free;

  // Pairing and output register update.
  always_comb begin
    have_left_nxt = have_left_r;
    left_nxt      = left_r;
    left_col_nxt  = left_col_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    o_left_nxt    = o_left_r;
    o_right_nxt   = o_right_r;
    o_rv_nxt      = o_rv_r;
    o_col_nxt     = o_col_r;
    o_row_nxt     = o_row_r;
    o_last_nxt    = o_last_r;
    o_rend_nxt    = o_rend_r;
    o_iend_nxt    = o_iend_r;
    if (evt_take) begin
      if (have_left_r || evt.last) begin
        out_vld_nxt   = 1'b1;
        o_left_nxt    = have_left_r ? left_r : pixel;
        o_right_nxt   = have_left_r ? pixel : '0;
        o_rv_nxt      = have_left_r;
        o_col_nxt     = have_left_r ? left_col_r : evt.col;
        o_row_nxt     = evt.row;
        o_last_nxt    = evt.last;
        o_rend_nxt    = evt.last && evt.ended;
        o_iend_nxt    = evt.last && evt.done;
        have_left_nxt = 1'b0;
      end else begin
        left_nxt      = pixel;
        left_col_nxt  = evt.col;
        have_left_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_left_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      have_left_r <= have_left_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r     <= left_nxt;
    left_col_r <= left_col_nxt;
    o_left_r   <= o_left_nxt;
    o_right_r  <= o_right_nxt;
    o_rv_r     <= o_rv_nxt;
    o_col_r    <= o_col_nxt;
    o_row_r    <= o_row_nxt;
    o_last_r   <= o_last_nxt;
    o_rend_r   <= o_rend_nxt;
    o_iend_r   <= o_iend_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = o_rv_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {3'b000, o_iend_r, o_rend_r, o_row_r, o_col_r, o_right_r, o_left_r};

  // A lone left pixel carries a zero right word.
  a_right_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !o_rv_r |-> (o_right_r == '0))
    else $error("right pixel not cleared");

  // Row end only on the last word of a burst.
  a_rend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && o_rend_r |-> o_last_r)
    else $error("row end before end of burst");

  // A pending left pixel never survives the end of its burst.
  a_left_flush: assert property (@(posedge clk) disable iff (!rst_n)
    evt_take && evt.last |=> !have_left_r)
    else $error("left pixel left over after burst");

endmodule

### hdl/rgbe_rle_scanline_decoder.sv
// Top level of the RGBE run-length scanline decoder.
// Depends on rrd_pkg, rrd_ram, rrd_seq and rrd_pack.
//
//   Channel   Ports                              Moves
//   in_       tvalid tready tdata[7:0]           one coded byte per word
//   out_      tvalid tready tdata tuser tlast    one or two RGBE pixels per word
//   cfg_      valid ready index data             register writes, always ready
//
// Header and count bytes are accepted while idle. A literal byte writes one column;
// a run value writes its columns one after another in the column loop, and no byte
// is accepted while that loop runs. Each E-plane column also waits on the registered
// row store read and a free output slot. Output stalls hold the E-plane loop on its
// current pixel. Reset is synchronous and active low; the row store is not cleared.
module rgbe_rle_scanline_decoder #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // code_byte [7:0]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rrd_pkg::BYTE_W-1:0]          in_tdata,
  // left_pixel [31:0], right_pixel [63:32], column [75:64], row [90:76],
  // row_end [91], image_end [92], zero [95:93]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rrd_pkg::OUT_DATA_W-1:0]      out_tdata,
  // right_valid [0]
  output logic                                out_tuser,
  // burst_last
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rrd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rrd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [WIDTH_W-1:0] width_r;
  logic [ROW_W-1:0]   height_r;
  logic [2:0]         row_we;
  logic               row_re;
  logic [COL_W-1:0]   row_addr;
  logic [BYTE_W-1:0]  row_wdata;
  logic [BYTE_W-1:0]  r_byte, g_byte, b_byte;
  pix_evt_t           evt;
  logic               evt_take;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd1024;
      height_r <= 15'd512;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        width_r <= cfg_data[WIDTH_W-1:0];
      end else if (cfg_index == REG_HEIGHT) begin
        height_r <= cfg_data[ROW_W-1:0];
      end
    end
  end

  rrd_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .image_height (height_r),
    .byte_vld     (in_tvalid),
    .byte_rdy     (in_tready),
    .byte_in      (in_tdata),
    .row_we       (row_we),
    .row_re       (row_re),
    .row_addr     (row_addr),
    .row_wdata    (row_wdata),
    .evt          (evt),
    .evt_take     (evt_take)
  );

  // Row store, one RAM per color plane.
  rrd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_WIDTH)) u_ram_r (
    .clk (clk), .wr_en (row_we[0]), .wr_addr (row_addr), .wr_data (row_wdata),
    .rd_en (row_re), .rd_addr (row_addr), .rd_data (r_byte)
  );

  rrd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_WIDTH)) u_ram_g (
    .clk (clk), .wr_en (row_we[1]), .wr_addr (row_addr), .wr_data (row_wdata),
    .rd_en (row_re), .rd_addr (row_addr), .rd_data (g_byte)
  );

  rrd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_WIDTH)) u_ram_b (
    .clk (clk), .wr_en (row_we[2]), .wr_addr (row_addr), .wr_data (row_wdata),
    .rd_en (row_re), .rd_addr (row_addr), .rd_data (b_byte)
  );

  rrd_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt        (evt),
    .rgb        ({r_byte, g_byte, b_byte}),
    .evt_take   (evt_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### test/rgbe_rle_scanline_decoder_test.sv
// Self-checking bench for the RGBE run-length scanline decoder: coded bytes in, pixel words out.
// Depends on rrd_pkg and the decoder RTL; a scoreboard class predicts every pixel word.
module rgbe_rle_scanline_decoder_test;
  import rrd_pkg::*;

  localparam int STORE_DEPTH  = 4096;
  localparam int RANDOM_BYTES = 160;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 600;
  localparam int QUIET_LIMIT  = 5000;

  // Header bytes and the start of a red plane at the reset width.
  localparam logic [BYTE_W-1:0] RED_OPENING [9] = '{
    8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'hA5, 8'h02, 8'h00, 8'hFF
  };
  // Rest of the first row once the width has dropped to five columns.
  localparam logic [BYTE_W-1:0] CUT_ROW [16] = '{
    8'h81, 8'h3C,
    8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55,
    8'hFF, 8'h5A,
    8'h82, 8'h81, 8'h00, 8'h01, 8'h80, 8'hFE
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  hold_req   = 1'b0;
  logic                  calm       = 1'b0;
  int unsigned           quiet      = 0;

  typedef struct {
    bit [PIXEL_W-1:0]  left_px;
    bit [PIXEL_W-1:0]  right_px;
    bit                right_valid;
    bit [COLUMN_W-1:0] column;
    bit [ROW_W-1:0]    row;
    bit                burst_last;
    bit                row_end;
    bit                image_end;
  } pixel_word_t;

  // Tracks the decoder state and queues the pixel words each byte should produce.
  class pixel_scoreboard;
    bit [WIDTH_W-1:0]  width_reg;
    bit [ROW_W-1:0]    height_reg;
    bit [RGB_W-1:0]    rgb_store [STORE_DEPTH];
    bit [COLUMN_W-1:0] column_at;
    bit [1:0]          plane;
    bit [ROW_W-1:0]    row_at;
    bit [HDR_W-1:0]    header_left;
    bit [SPAN_W-1:0]   span_left;
    bit                await_value;
    bit                image_done;
    pixel_word_t       due_words [$];
    int unsigned       errors;

    function new();
      width_reg   = 13'd1024;
      height_reg  = 15'd512;
      header_left = HEADER_BYTES;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_WIDTH) width_reg = val[WIDTH_W-1:0];
      else if (idx == REG_HEIGHT) height_reg = val[ROW_W-1:0];
    endfunction

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > STORE_DEPTH) return STORE_DEPTH;
      return int'(width_reg);
    endfunction

    function int eff_height();
      return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    // Writes one byte at the current column and plane; returns 1 when the plane ends.
    function bit put_byte(bit [BYTE_W-1:0] b, output bit [PIXEL_W-1:0] pix,
                          output bit [COLUMN_W-1:0] col);
      bit [RGB_W-1:0] rgb;
      rgb = rgb_store[column_at];
      col = column_at;
      pix = '0;
      if (plane == PLANE_E) begin
        pix = {rgb, b};
      end else begin
        rgb[(2 - plane) * BYTE_W +: BYTE_W] = b;
        rgb_store[column_at] = rgb;
      end
      if (column_at + 1 < eff_width()) begin
        column_at++;
        return 1'b0;
      end
      // The plane is complete; a finished exponent plane closes the row.
      column_at   = '0;
      span_left   = '0;
      await_value = 1'b0;
      if (plane == PLANE_E) begin
        plane       = '0;
        header_left = HEADER_BYTES;
        if (row_at + 1 >= eff_height()) image_done = 1'b1;
        else row_at++;
      end else begin
        plane++;
      end
      return 1'b1;
    endfunction

    function void decode_byte(bit [BYTE_W-1:0] b);
      bit [PIXEL_W-1:0]  pix [$];
      bit [COLUMN_W-1:0] cols [$];
      bit [PIXEL_W-1:0]  p;
      bit [COLUMN_W-1:0] c;
      bit [ROW_W-1:0]    row_of;
      bit                e_plane;
      bit                run_value;
      bit                ended;
      bit                done_here;
      pixel_word_t       w;
      int                k;
      if (image_done) return;
      if (header_left != 0) begin
        header_left--;
        return;
      end
      row_of  = row_at;
      e_plane = (plane == PLANE_E);
      ended   = 1'b0;
      // Count byte: above the bias starts a run, otherwise a literal span.
      if (!await_value && span_left == 0) begin
        if (b > RUN_BIAS) begin
          await_value = 1'b1;
          span_left   = {1'b0, b} - {1'b0, RUN_BIAS};
        end else begin
          span_left = (b == 0) ? LIT_FULL : {1'b0, b};
        end
        return;
      end
      // A run value fills columns until its count or the plane runs out;
      // a literal fills a single column.
      run_value   = await_value;
      await_value = 1'b0;
      do begin
        span_left--;
        ended = put_byte(b, p, c);
        if (e_plane) begin
          pix.push_back(p);
          cols.push_back(c);
        end
      end while (run_value && span_left != 0 && !ended);
      done_here = ended && e_plane && image_done;
      // Pixels leave in pairs of neighboring columns.
      for (k = 0; k < pix.size(); k += 2) begin
        w.left_px     = pix[k];
        w.right_valid = (k + 1 < pix.size());
        w.right_px    = w.right_valid ? pix[k+1] : '0;
        w.column      = cols[k];
        w.row         = row_of;
        w.burst_last  = (k + 2 >= pix.size());
        w.row_end     = w.burst_last && ended;
        w.image_end   = w.burst_last && done_here;
        due_words.push_back(w);
      end
    endfunction

    function void compare_field(string name, logic [PIXEL_W-1:0] actual,
                                bit [PIXEL_W-1:0] expected);
      if (actual !== expected) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, expected, actual);
      end
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] data, logic user, logic lastf);
      pixel_word_t w;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: word expected none actual %h", $time, data);
        return;
      end
      w = due_words.pop_front();
      compare_field("left_pixel", data[31:0], w.left_px);
      compare_field("right_pixel", data[63:32], w.right_px);
      compare_field("column", PIXEL_W'(data[75:64]), PIXEL_W'(w.column));
      compare_field("row", PIXEL_W'(data[90:76]), PIXEL_W'(w.row));
      compare_field("row_end", PIXEL_W'(data[91]), PIXEL_W'(w.row_end));
      compare_field("image_end", PIXEL_W'(data[92]), PIXEL_W'(w.image_end));
      compare_field("padding", PIXEL_W'(data[95:93]), '0);
      compare_field("right_valid", PIXEL_W'(user), PIXEL_W'(w.right_valid));
      compare_field("burst_last", PIXEL_W'(lastf), PIXEL_W'(w.burst_last));
    endfunction
  endclass

  pixel_scoreboard sb = new();

  rgbe_rle_scanline_decoder #(
    .MAX_WIDTH(STORE_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every accepted pixel word and stop the run if all traffic dries up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
        $display("rgbe_rle_scanline_decoder: mismatch");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Output side: random stall bursts, one long hold-off on request, none once calm.
  initial begin : receiver
    bit hold_taken;
    hold_taken = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.decode_byte(b);
  endtask

  // Wait for every predicted word, then let trailing column work finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Picks the next byte from the decoder state: mostly spans that fit the
  // plane, sometimes any byte, which may overrun the plane end.
  function automatic logic [BYTE_W-1:0] next_code(input bit wide);
    int room;
    int len;
    if (sb.header_left != 0 || sb.await_value || sb.span_left != 0)
      return BYTE_W'($urandom_range(0, 255));
    room = sb.eff_width() - sb.column_at;
    if (room < 1) room = 1;
    len = (room < 127) ? room : 127;
    if (!wide) begin
      if ($urandom_range(0, 4) == 0) return BYTE_W'($urandom_range(0, 255));
      len = $urandom_range(1, len);
    end
    if (wide || $urandom_range(0, 1) == 0) return RUN_BIAS + BYTE_W'(len);
    return BYTE_W'(len);
  endfunction

  task automatic send_row(input bit wide, inout int unsigned sent);
    do begin
      if (wide && sb.plane == PLANE_E && !hold_req) hold_req <= 1'b1;
      send_byte(next_code(wide), !wide && !calm);
      sent++;
    end while (sb.header_left != HEADER_BYTES);
  endtask

  initial begin : stimulus
    int unsigned           sent;
    int unsigned           wide_bytes;
    bit                    wide;
    bit                    wide_done;
    logic [CFG_DATA_W-1:0] width;
    sent       = 0;
    wide_bytes = 0;
    wide_done  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // At the reset width: header, a long run and a short literal in red.
    foreach (RED_OPENING[i]) send_byte(RED_OPENING[i], 1'b1);
    settle();
    // Narrow the row below the current column, then finish it with cut spans.
    write_reg(REG_WIDTH, 15'd5);
    foreach (CUT_ROW[i]) send_byte(CUT_ROW[i], 1'b1);
    settle();
    write_reg(REG_HEIGHT, 15'h7FFF);

    // Random rows at changing widths, with one full row at the widest setting.
    while (sent < RANDOM_BYTES) begin
      wide = !wide_done && sent >= RANDOM_BYTES / 3;
      settle();
      case ($urandom_range(0, 7))
        0:       width = '0;
        1:       width = 15'd13;
        default: width = CFG_DATA_W'($urandom_range(1, 8));
      endcase
      write_reg(REG_WIDTH, wide ? 15'h1FFF : width);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(1000, 32767)));
      end
      if (wide) begin
        send_row(1'b1, wide_bytes);
        wide_done = 1'b1;
      end else begin
        repeat ($urandom_range(1, 3)) send_row(1'b0, sent);
      end
    end

    // A zero height acts as one, so the next row closes the image.
    settle();
    calm <= 1'b1;
    write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(2, 6)));
    write_reg(REG_HEIGHT, '0);
    send_row(1'b0, sent);
    // Bytes past the last row are dropped.
    repeat (12) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) $display("rgbe_rle_scanline_decoder: match");
    else $display("rgbe_rle_scanline_decoder: mismatch");
    $finish;
  end

endmodule
